[design/sdcc_pkg.sv]
// ----------------------------------------------------------------------------
// sdcc_pkg
// Shared types, constants and helpers for the serial drive command controller.
// ----------------------------------------------------------------------------
package sdcc_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int POS_W        = 7;
    localparam int NUM_W        = 12;
    localparam logic [NUM_W-1:0] NUM_MAX = 12'd4095;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_ECHO = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;

    localparam logic [2:0] REG_STOP_PATTERN = 3'd0;
    localparam logic [2:0] REG_STOP_LENGTH  = 3'd1;
    localparam logic [2:0] REG_MIN_POWER    = 3'd2;
    localparam logic [2:0] REG_MIN_CLEAR    = 3'd3;
    localparam logic [2:0] REG_MAX_IDLE     = 3'd4;

    typedef enum logic [1:0] {
        PH_BLANK  = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  rx_byte;
        logic [19:0] echo_us;
    } in_item_t;

    typedef struct packed {
        logic        steer_left;
        logic        steer_brake;
        logic [8:0]  steer_power;
        logic        drive_reverse;
        logic        drive_brake;
        logic [8:0]  drive_power;
        logic [14:0] clearance_cm;
    } out_item_t;

    // Classified command passed from the front end to the back end.
    typedef enum logic [2:0] {
        OP_NONE  = 3'b001,
        OP_FRAME = 3'b010,
        OP_ECHO  = 3'b100
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        tick;
        logic        stop;
        logic [12:0] lr_num;   // bit 12 = negative
        logic [12:0] fb_num;
        logic [14:0] cm;
    } cmd_t;

    typedef struct packed {
        logic [63:0] stop_pattern;
        logic [3:0]  stop_length;
        logic [8:0]  min_motor_power;
        logic [9:0]  min_clearance_cm;
        logic [15:0] max_idle_ms;
    } cfg_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Map a parsed number to {dir, power}.
    function automatic logic [9:0] map_power(input logic [12:0] num);
        logic [11:0] v;
        logic [11:0] d;
        v = num[11:0];
        d = 12'd0;
        if (num[12] || v == 12'd0)
            return 10'd0;
        if (v < 12'd512)
        begin
            d = 12'd512 - v;
            return {1'b1, d[9:1]};
        end
        if (v > 12'd512 && v <= 12'd1024)
        begin
            d = v - 12'd512;
            return {1'b0, d[9:1]};
        end
        return 10'd0;
    endfunction

endpackage

[design/sdcc_front.sv]
// ----------------------------------------------------------------------------
// sdcc_front
// Parses command bytes, divides echo times, and emits one command per item.
// ----------------------------------------------------------------------------
module sdcc_front
    import sdcc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  in_item_t din,
    input  cfg_t     cfg,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output cmd_t     cmd
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             match_reg, match_next;
    logic [NUM_W-1:0] lr_val_reg, lr_val_next, fb_val_reg, fb_val_next;
    logic             lr_neg_reg, lr_neg_next, fb_neg_reg, fb_neg_next;
    phase_t           lr_ph_reg, lr_ph_next, fb_ph_reg, fb_ph_next;
    logic             comma_reg, comma_next;
    logic             valid_reg;
    cmd_t             cmd_reg, cmd_next;
    logic             take;
    logic [3:0]       slen;
    logic [20:0]      prod;
    logic [14:0]      q;

    assign full      = valid_reg && !cmd_ready;
    assign take      = push && !full;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;
    assign slen      = (cfg.stop_length > 4'd8) ? 4'd8 : cfg.stop_length;

    // us / 58 by reciprocal: floor(us * 18078 >> 20), then one correction
    always_comb
    begin
        logic [40:0] m;
        logic [20:0] r;
        m    = 41'(din.echo_us) * 41'd18078;
        q    = m[34:20];
        r    = 21'(din.echo_us) - 21'(q) * 21'd58;
        prod = r;
        if (r >= 21'd58)
            q = q + 15'd1;
    end

    function automatic logic [NUM_W+2:0] num_step(input phase_t ph, input logic [NUM_W-1:0] v,
                                                  input logic ng, input logic [7:0] c);
        logic [15:0] t;
        phase_t      p;
        t = 16'd0;
        p = ph;
        if (p == PH_BLANK)
        begin
            if (is_blank(c))
                return {p, ng, v};
            if (c == CH_PLUS)
                return {PH_SIGN, ng, v};
            if (c == CH_MINUS)
                return {PH_SIGN, 1'b1, v};
        end
        if (p == PH_DONE)
            return {p, ng, v};
        if (c >= 8'h30 && c <= 8'h39)
        begin
            t = 16'(v) * 16'd10 + 16'(c - 8'h30);
            return {PH_DIGITS, ng, (t > 16'(NUM_MAX)) ? NUM_MAX : t[NUM_W-1:0]};
        end
        return {PH_DONE, ng, v};
    endfunction

    always_comb
    begin
        logic [NUM_W+2:0] r;
        logic             clr;
        pos_next    = pos_reg;
        match_next  = match_reg;
        lr_val_next = lr_val_reg;
        lr_neg_next = lr_neg_reg;
        lr_ph_next  = lr_ph_reg;
        fb_val_next = fb_val_reg;
        fb_neg_next = fb_neg_reg;
        fb_ph_next  = fb_ph_reg;
        comma_next  = comma_reg;
        r           = '0;
        clr         = 1'b0;
        cmd_next        = '0;
        cmd_next.op     = OP_NONE;
        cmd_next.lr_num = comma_reg ? {lr_neg_reg, lr_val_reg} : 13'd0;
        cmd_next.fb_num = {fb_neg_reg, fb_val_reg};
        cmd_next.stop   = (pos_reg >= POS_W'(slen)) && match_reg;
        cmd_next.cm     = q;
        cmd_next.tick   = din.kind == KIND_TICK;
        case (din.kind)
            KIND_BYTE:
            begin
                if (din.rx_byte == CH_AT)
                begin
                    cmd_next.op = OP_FRAME;
                    clr         = 1'b1;
                end
                else
                begin
                    if (din.rx_byte == CH_DOLLAR)
                    begin
                        pos_next = '0; match_next = 1'b1; comma_next = 1'b0;
                        lr_val_next = '0; lr_neg_next = 1'b0; lr_ph_next = PH_BLANK;
                        fb_val_next = '0; fb_neg_next = 1'b0; fb_ph_next = PH_BLANK;
                    end
                    if (32'(pos_next) < BUFFER_DEPTH)
                    begin
                        if (pos_next < POS_W'(slen) && din.rx_byte !=
                            cfg.stop_pattern[{pos_next[2:0], 3'b000} +: 8])
                            match_next = 1'b0;
                        if (pos_next != '0)
                        begin
                            if (din.rx_byte == CH_COMMA)
                            begin
                                if (!comma_next)
                                    lr_ph_next = PH_DONE;
                                comma_next  = 1'b1;
                                fb_val_next = '0; fb_neg_next = 1'b0; fb_ph_next = PH_BLANK;
                            end
                            else
                            begin
                                if (!comma_next)
                                begin
                                    r = num_step(lr_ph_next, lr_val_next, lr_neg_next,
                                                 din.rx_byte);
                                    {lr_ph_next, lr_neg_next, lr_val_next} = r;
                                end
                                r = num_step(fb_ph_next, fb_val_next, fb_neg_next, din.rx_byte);
                                {fb_ph_next, fb_neg_next, fb_val_next} = r;
                            end
                        end
                        pos_next = pos_next + POS_W'(1);
                    end
                end
            end
            KIND_ECHO: cmd_next.op = OP_ECHO;
            default: ;
        endcase
        if (clr)
        begin
            pos_next = '0; match_next = 1'b1; comma_next = 1'b0;
            lr_val_next = '0; lr_neg_next = 1'b0; lr_ph_next = PH_BLANK;
            fb_val_next = '0; fb_neg_next = 1'b0; fb_ph_next = PH_BLANK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0; match_reg <= 1'b1; comma_reg <= 1'b0;
            lr_val_reg <= '0; lr_neg_reg <= 1'b0; lr_ph_reg <= PH_BLANK;
            fb_val_reg <= '0; fb_neg_reg <= 1'b0; fb_ph_reg <= PH_BLANK;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                pos_reg <= pos_next; match_reg <= match_next; comma_reg <= comma_next;
                lr_val_reg <= lr_val_next; lr_neg_reg <= lr_neg_next; lr_ph_reg <= lr_ph_next;
                fb_val_reg <= fb_val_next; fb_neg_reg <= fb_neg_next; fb_ph_reg <= fb_ph_next;
                valid_reg <= 1'b1;
            end
            else if (cmd_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cmd_reg <= cmd_next;
    end

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) <= BUFFER_DEPTH) else $error("frame position overrun");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !cmd_ready |=> valid_reg && $stable(cmd_reg))
        else $error("command lost under stall");
    a_rem: assert property (@(posedge clk) disable iff (!rst_n)
        prod < 21'd116) else $error("echo quotient correction out of range");

endmodule

[design/sdcc_back.sv]
// ----------------------------------------------------------------------------
// sdcc_back
// Applies commands to motor state and queues one result per command.
// ----------------------------------------------------------------------------
module sdcc_back
    import sdcc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_t      cmd,
    input  cfg_t      cfg,
    output logic      empty,
    input  logic      pop,
    output out_item_t dout
);

    out_item_t   st_reg, st_next;
    logic [15:0] idle_reg, idle_next;
    out_item_t   q_reg [2];
    logic [1:0]  cnt_reg;
    logic        rd_reg, wr_reg;
    logic        do_in, do_out;
    logic [9:0]  lm, fm;

    assign empty     = cnt_reg == 2'd0;
    assign dout      = q_reg[rd_reg];
    assign do_out    = pop && !empty;
    assign cmd_ready = (cnt_reg != 2'd2) || do_out;
    assign do_in     = cmd_valid && cmd_ready;
    assign lm        = map_power(cmd.lr_num);
    assign fm        = map_power(cmd.fb_num);

    always_comb
    begin
        st_next   = st_reg;
        idle_next = idle_reg;
        case (cmd.op)
            OP_FRAME:
            begin
                idle_next = '0;
                if (cmd.stop)
                begin
                    st_next.steer_brake = 1'b1;
                    st_next.drive_brake = 1'b1;
                end
                else
                begin
                    if (lm[8:0] > cfg.min_motor_power)
                    begin
                        st_next.steer_left  = lm[9];
                        st_next.steer_brake = 1'b0;
                        st_next.steer_power = lm[8:0];
                    end
                    else
                        st_next.steer_brake = 1'b1;
                    if (fm[8:0] > cfg.min_motor_power)
                    begin
                        st_next.drive_reverse = fm[9];
                        st_next.drive_brake   = 1'b0;
                        st_next.drive_power   = fm[8:0];
                    end
                    else
                        st_next.drive_brake = 1'b1;
                end
            end
            OP_ECHO:
            begin
                st_next.clearance_cm = cmd.cm;
                if (cmd.cm < 15'(cfg.min_clearance_cm))
                begin
                    st_next.steer_brake = 1'b1;
                    st_next.drive_brake = 1'b1;
                end
            end
            default:
            begin
                if (cmd.tick)
                begin
                    if (idle_reg != 16'hFFFF)
                        idle_next = idle_reg + 16'd1;
                    if (idle_next > cfg.max_idle_ms)
                    begin
                        st_next.steer_brake = 1'b1;
                        st_next.drive_brake = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= '0;
            idle_reg <= '0;
            cnt_reg  <= '0;
            rd_reg   <= 1'b0;
            wr_reg   <= 1'b0;
        end
        else
        begin
            if (do_in)
            begin
                st_reg   <= st_next;
                idle_reg <= idle_next;
                wr_reg   <= !wr_reg;
            end
            if (do_out)
                rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + 2'(do_in) - 2'(do_out);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_in)
            q_reg[wr_reg] <= st_next;
    end

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2) else $error("result queue overflow");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd1) |-> (rd_reg != wr_reg)) else $error("queue pointers skewed");
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        do_in && cmd.op == OP_FRAME |=> idle_reg == 16'd0) else $error("idle not cleared");

endmodule

[design/sdcc_regs.sv]
// ----------------------------------------------------------------------------
// sdcc_regs
// APB configuration register file.
// ----------------------------------------------------------------------------
module sdcc_regs
    import sdcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic [2:0] idx;

    assign idx    = paddr[5:3];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        case (idx)
            REG_STOP_PATTERN: prdata = cfg_reg.stop_pattern;
            REG_STOP_LENGTH:  prdata = 64'(cfg_reg.stop_length);
            REG_MIN_POWER:    prdata = 64'(cfg_reg.min_motor_power);
            REG_MIN_CLEAR:    prdata = 64'(cfg_reg.min_clearance_cm);
            REG_MAX_IDLE:     prdata = 64'(cfg_reg.max_idle_ms);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stop_pattern     <= 64'd21284;
            cfg_reg.stop_length      <= 4'd2;
            cfg_reg.min_motor_power  <= 9'd0;
            cfg_reg.min_clearance_cm <= 10'd20;
            cfg_reg.max_idle_ms      <= 16'd1000;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                REG_STOP_PATTERN: cfg_reg.stop_pattern     <= pwdata;
                REG_STOP_LENGTH:  cfg_reg.stop_length      <= pwdata[3:0];
                REG_MIN_POWER:    cfg_reg.min_motor_power  <= pwdata[8:0];
                REG_MIN_CLEAR:    cfg_reg.min_clearance_cm <= pwdata[9:0];
                REG_MAX_IDLE:     cfg_reg.max_idle_ms      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

endmodule

[design/serial_drive_command_controller.sv]
// ----------------------------------------------------------------------------
// serial_drive_command_controller
// Channel   Handshake          Payload
// input     push / full        in_item_t  (kind, rx_byte, echo_us)
// result    empty / pop        out_item_t (motor state, clearance)
// config    APB psel/penable   64-bit registers at 8*i
// One item per cycle while full is low; items pass the parser register, then
// motor state update into a two-entry result queue. rst_n is asynchronous.
// full rises only when the result queue and the parser register are both
// occupied and pop is low.
// ----------------------------------------------------------------------------
module serial_drive_command_controller
    import sdcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_item_t    din,
    output logic        empty,
    input  logic        pop,
    output out_item_t   dout,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    cfg_t cfg;
    cmd_t cmd;
    logic cmd_valid, cmd_ready;

    sdcc_regs u_regs (.clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
                      .prdata, .pready, .cfg);
    sdcc_front u_front (.clk, .rst_n, .push, .full, .din, .cfg, .cmd_valid,
                        .cmd_ready, .cmd);
    sdcc_back u_back (.clk, .rst_n, .cmd_valid, .cmd_ready, .cmd, .cfg, .empty,
                      .pop, .dout);

endmodule
